// ===== rtl/bla_pkg.sv =====
// shared constants and types for the battery level averager
package bla_pkg;

    localparam int WINDOW      = 8;
    localparam int SAMPLE_W    = 12;
    localparam int PCT_W       = 7;
    localparam int SLOT_W      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W       = $clog2(WINDOW + 1);
    localparam int SUM_W       = SAMPLE_W + CNT_W;
    localparam int PCT_NUM_W   = SAMPLE_W + 7;
    localparam int DIV_NUM_W   = (SUM_W > PCT_NUM_W) ? SUM_W : PCT_NUM_W;
    localparam int DIV_DEN_W   = SAMPLE_W;
    localparam int DIV_STEP_W  = $clog2(DIV_NUM_W + 1);
    localparam int FULL_SCALE  = 100;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;

    localparam logic REG_FLOOR   = 1'b0;
    localparam logic REG_CEILING = 1'b1;

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] count;
    } t_win_status;

endpackage

// ===== rtl/bla_window.sv =====
// sample ring with a serial nonzero sum and count pass
module bla_window
    import bla_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  logic [SAMPLE_W-1:0] i_sample,
    output t_win_status         o_status
);

    logic [SAMPLE_W-1:0] r_store [WINDOW];
    logic [SLOT_W-1:0]   r_slot;
    logic [SLOT_W-1:0]   n_slot;
    logic [SLOT_W-1:0]   r_idx;
    logic                r_busy;
    logic                r_done;
    logic [SUM_W-1:0]    r_sum;
    logic [CNT_W-1:0]    r_count;

    assign n_slot = (r_slot == SLOT_W'(WINDOW - 1)) ? '0 : r_slot + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WINDOW; k++) begin
                r_store[k] <= '0;
            end
            r_slot  <= '0;
            r_idx   <= '0;
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_sum   <= '0;
            r_count <= '0;
        end else begin
            r_done <= !i_load && r_busy && (r_idx == SLOT_W'(WINDOW - 1));
            if (i_load) begin
                r_slot          <= n_slot;
                r_store[n_slot] <= i_sample;
                r_idx           <= '0;
                r_busy          <= 1'b1;
                r_sum           <= '0;
                r_count         <= '0;
            end else if (r_busy) begin
                if (r_store[r_idx] != '0) begin
                    r_sum   <= r_sum + SUM_W'(r_store[r_idx]);
                    r_count <= r_count + 1'b1;
                end
                if (r_idx == SLOT_W'(WINDOW - 1)) begin
                    r_busy <= 1'b0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
        end
    end

    assign o_status.done  = r_done;
    assign o_status.sum   = r_sum;
    assign o_status.count = r_count;

endmodule

// ===== rtl/bla_serial_div.sv =====
// restoring divider, one quotient bit per cycle
module bla_serial_div
    import bla_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [DIV_NUM_W-1:0] i_num,
    input  logic [DIV_DEN_W-1:0] i_den,
    output logic                 o_done,
    output logic [DIV_NUM_W-1:0] o_quot
);

    logic [DIV_NUM_W-1:0]  r_num;
    logic [DIV_DEN_W-1:0]  r_den;
    logic [DIV_DEN_W-1:0]  r_rem;
    logic [DIV_STEP_W-1:0] r_step;
    logic                  r_busy;
    logic                  r_done;
    logic [DIV_DEN_W:0]    trial;
    logic                  fits;

    assign trial = {r_rem, r_num[DIV_NUM_W-1]};
    assign fits  = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_step == DIV_STEP_W'(1));
            if (i_start) begin
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_step <= DIV_STEP_W'(DIV_NUM_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem  <= fits ? DIV_DEN_W'(trial - {1'b0, r_den}) : DIV_DEN_W'(trial);
                r_num  <= {r_num[DIV_NUM_W-2:0], fits};
                r_step <= r_step - 1'b1;
                if (r_step == DIV_STEP_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

// ===== rtl/battery_level_averager.sv =====
// top level: sample ring, averaging and percent mapping sequencer
//
// input beats on s_axis carry one 12-bit converter sample each; output beats
// on m_axis carry the charge percent and the window average. two registers,
// floor and ceiling, are written through i_cfg_we / i_cfg_index / i_cfg_data.
// one result beat comes out for every input beat, in order.
// output valid rises after the ring scan (one entry a cycle), the average
// division (start, load, 19 quotient bits at one bit a cycle, capture), the
// mapping state and the percent division, and the load of the output register;
// both divisions share one restoring divider. an empty ring or a mapping that
// falls outside the span skips the matching division.
// one item is in work at a time, so the next input beat is taken only once
// the previous result has been loaded into the output register.
// a new sample is taken while a previous result still waits on m_axis; the
// finished result then holds until the output register frees.
// a stalled receiver keeps m_axis_tdata stable and blocks further results.
// reset clears the ring to zero, the write slot to zero, floor to 0 and
// ceiling to 4095.
module battery_level_averager
    import bla_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // sample[11:0], zero pad
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // percent[6:0], average[18:7], pad
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_index,
    input  logic [SAMPLE_W-1:0]    i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUM,
        S_DIV_AVG,
        S_MAP,
        S_DIV_PCT,
        S_WRITE
    } t_state;

    t_state               r_state;
    logic [SAMPLE_W-1:0]  r_floor;
    logic [SAMPLE_W-1:0]  r_ceiling;
    logic [SAMPLE_W-1:0]  r_avg;
    logic [PCT_W-1:0]     r_pct;
    logic                 r_out_valid;
    logic [SAMPLE_W-1:0]  r_out_avg;
    logic [PCT_W-1:0]     r_out_pct;
    logic                 r_div_start;
    logic [DIV_NUM_W-1:0] r_div_num;
    logic [DIV_DEN_W-1:0] r_div_den;

    logic                 in_beat;
    t_win_status          win;
    logic                 div_done;
    logic [DIV_NUM_W-1:0] div_quot;
    logic [SAMPLE_W-1:0]  diff;
    logic [PCT_NUM_W-1:0] scaled;
    logic                 map_zero;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    assign diff     = r_avg - r_floor;
    assign scaled   = PCT_NUM_W'({diff, 6'b0}) + PCT_NUM_W'({diff, 5'b0})
                    + PCT_NUM_W'({diff, 2'b0});
    assign map_zero = (r_ceiling <= r_floor) || (r_avg < r_floor);

    bla_window u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (in_beat),
        .i_sample (s_axis_tdata[SAMPLE_W-1:0]),
        .o_status (win)
    );

    bla_serial_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_div_num),
        .i_den   (r_div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor   <= '0;
            r_ceiling <= '1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_FLOOR:   r_floor   <= i_cfg_data;
                REG_CEILING: r_ceiling <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_div_start <= 1'b0;
        end else begin
            r_div_start <= ((r_state == S_SUM) && win.done && (win.count != '0))
                         || ((r_state == S_MAP) && !map_zero);
            if (r_out_valid && m_axis_tready && (r_state != S_WRITE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_beat) begin
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    if (win.done) begin
                        if (win.count == '0) begin
                            r_avg   <= '0;
                            r_state <= S_MAP;
                        end else begin
                            r_div_num <= DIV_NUM_W'(win.sum);
                            r_div_den <= DIV_DEN_W'(win.count);
                            r_state   <= S_DIV_AVG;
                        end
                    end
                end
                S_DIV_AVG: begin
                    if (div_done) begin
                        r_avg   <= div_quot[SAMPLE_W-1:0];
                        r_state <= S_MAP;
                    end
                end
                S_MAP: begin
                    if (map_zero) begin
                        r_pct   <= '0;
                        r_state <= S_WRITE;
                    end else begin
                        r_div_num <= DIV_NUM_W'(scaled);
                        r_div_den <= r_ceiling - r_floor;
                        r_state   <= S_DIV_PCT;
                    end
                end
                S_DIV_PCT: begin
                    if (div_done) begin
                        if (div_quot > DIV_NUM_W'(FULL_SCALE)) begin
                            r_pct <= PCT_W'(FULL_SCALE);
                        end else begin
                            r_pct <= div_quot[PCT_W-1:0];
                        end
                        r_state <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_avg   <= r_avg;
                        r_out_pct   <= r_pct;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W - SAMPLE_W - PCT_W){1'b0}}, r_out_avg, r_out_pct};

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// self-checking stream testbench for the battery level averager
module tb;
    import bla_pkg::*;

    typedef enum logic [1:0] {FEED_SAMPLE, FEED_REG_WRITE, FEED_SETTLE} t_feed_kind;

    typedef struct {
        t_feed_kind          kind;
        logic                reg_index;
        logic [SAMPLE_W-1:0] value;
    } t_feed;

    typedef struct {
        logic [PCT_W-1:0]    percent;
        logic [SAMPLE_W-1:0] average;
    } t_level;

    localparam int IDLE_PCT      = 27;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 60;
    localparam int RANDOM_ITEMS  = 1600;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   i_cfg_we      = 1'b0;
    logic                   i_cfg_index   = REG_FLOOR;
    logic [SAMPLE_W-1:0]    i_cfg_data    = '0;

    t_feed               pending[$];
    t_level              level_store[$];
    logic [SAMPLE_W-1:0] ring_copy [WINDOW];
    int unsigned         slot_copy     = 0;
    logic [SAMPLE_W-1:0] floor_copy    = '0;
    logic [SAMPLE_W-1:0] ceiling_copy  = '1;
    int unsigned         samples_in    = 0;
    int unsigned         next_hold_at  = 40;
    int unsigned         hold_left     = 0;
    int unsigned         gap_left      = 0;
    int unsigned         mismatches    = 0;
    bit                  sample_beat   = 1'b0;

    wire quiet = (samples_in >= 600) && (samples_in < 900);

    battery_level_averager DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic t_level gauge_step(logic [SAMPLE_W-1:0] sample);
        t_level      lv;
        int unsigned sum;
        int unsigned count;
        int unsigned avg;
        int unsigned pct;
        sum   = 0;
        count = 0;
        avg   = 0;
        pct   = 0;
        slot_copy = (slot_copy + 1) % WINDOW;
        ring_copy[slot_copy] = sample;
        for (int k = 0; k < WINDOW; k++) begin
            if (ring_copy[k] != 0) begin
                sum += ring_copy[k];
                count++;
            end
        end
        if (count != 0) begin
            avg = sum / count;
        end
        if (ceiling_copy > floor_copy && avg >= floor_copy) begin
            pct = (FULL_SCALE * (avg - floor_copy)) / (ceiling_copy - floor_copy);
            if (pct > FULL_SCALE) begin
                pct = FULL_SCALE;
            end
        end
        lv.percent = PCT_W'(pct);
        lv.average = SAMPLE_W'(avg);
        return lv;
    endfunction

    function automatic void push_sample(logic [SAMPLE_W-1:0] value);
        pending.push_back('{FEED_SAMPLE, REG_FLOOR, value});
    endfunction

    function automatic void set_span(logic [SAMPLE_W-1:0] lo, logic [SAMPLE_W-1:0] hi);
        pending.push_back('{FEED_REG_WRITE, REG_FLOOR, lo});
        pending.push_back('{FEED_REG_WRITE, REG_CEILING, hi});
    endfunction

    // driver
    always @(negedge i_clk) begin
        logic                  offer;
        logic [IN_TDATA_W-1:0] data;
        logic                  we;
        offer = s_axis_tvalid && !sample_beat;
        data  = s_axis_tdata;
        we    = 1'b0;
        if (i_rst_n && !offer) begin
            if (gap_left != 0) begin
                gap_left--;
            end else if (pending.size() != 0) begin
                case (pending[0].kind)
                    FEED_SAMPLE: begin
                        if (quiet || $urandom_range(99) >= IDLE_PCT) begin
                            offer = 1'b1;
                            data  = IN_TDATA_W'(pending[0].value);
                            void'(pending.pop_front());
                            if (!quiet && $urandom_range(99) < 4) begin
                                gap_left = $urandom_range(70, 1);
                            end
                        end
                    end
                    FEED_REG_WRITE: begin
                        if (level_store.size() == 0) begin
                            we = 1'b1;
                            i_cfg_index <= pending[0].reg_index;
                            i_cfg_data  <= pending[0].value;
                            void'(pending.pop_front());
                        end
                    end
                    FEED_SETTLE: begin
                        if (level_store.size() == 0) begin
                            void'(pending.pop_front());
                        end
                    end
                    default: begin
                        void'(pending.pop_front());
                    end
                endcase
            end
        end
        s_axis_tvalid <= offer;
        s_axis_tdata  <= data;
        i_cfg_we      <= we;
    end

    // receiver
    always @(negedge i_clk) begin
        m_axis_tready <= (hold_left == 0) && (quiet || $urandom_range(99) >= IDLE_PCT);
    end

    // long receiver hold-off so the block backs up into its input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (samples_in >= next_hold_at) begin
            hold_left    <= HOLD_CYCLES;
            next_hold_at <= next_hold_at + 700;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_level got;
        t_level want;
        sample_beat = 1'b0;
        if (!i_rst_n) begin
            foreach (ring_copy[k]) begin
                ring_copy[k] = '0;
            end
            slot_copy    = 0;
            floor_copy   = '0;
            ceiling_copy = '1;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_FLOOR) begin
                    floor_copy = i_cfg_data;
                end else begin
                    ceiling_copy = i_cfg_data;
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                sample_beat = 1'b1;
                level_store.push_back(gauge_step(s_axis_tdata[SAMPLE_W-1:0]));
                samples_in <= samples_in + 1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.percent = m_axis_tdata[PCT_W-1:0];
                got.average = m_axis_tdata[PCT_W +: SAMPLE_W];
                if (level_store.size() == 0) begin
                    $error("result beat with no sample pending: percent %0d, average %0d",
                           got.percent, got.average);
                    mismatches++;
                end else begin
                    want = level_store.pop_front();
                    if (got.percent !== want.percent) begin
                        $error("percent: expected %0d, actual %0d", want.percent, got.percent);
                        mismatches++;
                    end
                    if (got.average !== want.average) begin
                        $error("average: expected %0d, actual %0d", want.average, got.average);
                        mismatches++;
                    end
                end
            end
        end
    end

    initial begin
        int unsigned lo;
        int unsigned hi;
        int unsigned pick;
        lo = 0;
        hi = 4095;

        // directed
        push_sample(12'h000);
        push_sample(12'hFFF);
        push_sample(12'h001);
        push_sample(12'hAAA);
        push_sample(12'h555);
        set_span(12'd3000, 12'd4095);
        push_sample(12'd3000);
        set_span(12'd0, 12'd1000);
        push_sample(12'd1000);
        set_span(12'd0, 12'd1);
        push_sample(12'd1);
        set_span(12'd2000, 12'd2000);
        push_sample(12'd2500);
        set_span(12'd4095, 12'd0);
        push_sample(12'd4095);
        set_span(12'd0, 12'd4095);
        repeat (WINDOW) push_sample(12'h000);
        pending.push_back('{FEED_SETTLE, REG_FLOOR, '0});

        // random
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 200 == 0) begin
                pick = $urandom_range(9);
                case (pick)
                    0: begin
                        lo = 0;
                        hi = 4095;
                    end
                    1: begin
                        lo = 4095;
                        hi = 0;
                    end
                    2: begin
                        lo = $urandom_range(4095);
                        hi = lo;
                    end
                    3: begin
                        lo = $urandom_range(4094);
                        hi = lo + 1;
                    end
                    default: begin
                        lo = $urandom_range(3500);
                        hi = $urandom_range(4095, lo + 1);
                    end
                endcase
                set_span(SAMPLE_W'(lo), SAMPLE_W'(hi));
            end else if (n % 200 == 100) begin
                pending.push_back('{FEED_SETTLE, REG_FLOOR, '0});
            end
            pick = $urandom_range(99);
            if (pick < 8) begin
                push_sample(12'h000);
            end else if (pick < 10) begin
                repeat (WINDOW) push_sample(12'h000);
            end else if (pick < 14) begin
                push_sample(pick[0] ? 12'hFFF : 12'h001);
            end else if (pick < 60 && hi > lo) begin
                push_sample(SAMPLE_W'($urandom_range(hi, lo)));
            end else begin
                push_sample(SAMPLE_W'($urandom_range(4095)));
            end
        end

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending.size() != 0 || s_axis_tvalid || level_store.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("battery_level_averager verification clean");
        end else begin
            $display("battery_level_averager verification failed");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("battery_level_averager verification failed");
        $finish;
    end

endmodule
